@@ hw/rtl/lif_neuron_update_assert.svh @@
// ----------------------------------------------------------------------------
// lif_neuron_update_assert.svh
// Assertion macros for the LIF neuron bank. The checks compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LIF_NEURON_UPDATE_ASSERT_SVH
`define LIF_NEURON_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high
`define LIF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define LIF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LIF_ASSERT(label, clk, rst, prop, msg)
`define LIF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ hw/rtl/lif_pkg.sv @@
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types and constants of the LIF neuron bank: beat payloads, the
// per-neuron state row, the register file and the controller commands.
// ----------------------------------------------------------------------------
package lif_pkg;

   localparam int DATA_W        = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int INDEX_W       = 8;
   localparam int INPUT_W       = 31;
   localparam int REF_COUNT_W   = 17;
   localparam int REF_LENGTH_W  = 15;
   // reversal difference and product scaling
   localparam int DIFF_SHIFT    = 7;
   localparam int PRODUCT_SHIFT = 10;
   localparam int DIFF_W        = DATA_W - DIFF_SHIFT;
   localparam int PROD_W        = DATA_W + DIFF_W;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REST_POTENTIAL      = 3'd0,
      CSR_EXCITATORY_REVERSAL = 3'd1,
      CSR_INHIBITORY_REVERSAL = 3'd2,
      CSR_INHIBITORY_CEILING  = 3'd3,
      CSR_THRESHOLD_INCREMENT = 3'd4,
      CSR_THRESHOLD_START     = 3'd5,
      CSR_REFRACTORY_LENGTH   = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_INIT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [INDEX_W-1:0]       neuron_index;
      logic [INPUT_W-1:0]       excitatory_input;
      logic [INPUT_W-1:0]       inhibitory_input;
      logic                     resting_phase;
   } req_payload_type;

   typedef struct packed {
      logic                     spike;
      logic signed [DATA_W-1:0] membrane;
      logic signed [DATA_W-1:0] threshold;
   } rsp_payload_type;

   // one row of the state memory
   typedef struct packed {
      logic signed [DATA_W-1:0] membrane;
      logic signed [DATA_W-1:0] threshold;
      logic signed [DATA_W-1:0] g_exc;
      logic signed [DATA_W-1:0] g_inh;
      logic [REF_COUNT_W-1:0]   ref_count;
      logic                     ref_flag;
   } neuron_state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] rest_potential;
      logic signed [DATA_W-1:0] excitatory_reversal;
      logic signed [DATA_W-1:0] inhibitory_reversal;
      logic [INPUT_W-1:0]       inhibitory_ceiling;
      logic [INPUT_W-1:0]       threshold_increment;
      logic signed [DATA_W-1:0] threshold_start;
      logic [REF_LENGTH_W-1:0]  refractory_length;
   } csr_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // input beat accepted, read the neuron row
      logic commit;    // write back the row and load the result register
      logic clear_en;  // clearing pass writes a zero row
   } lif_cmd_type;

endpackage

@@ hw/rtl/lif_stream_if.sv @@
// ----------------------------------------------------------------------------
// lif_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface lif_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

@@ hw/rtl/lif_ctrl.sv @@
// ----------------------------------------------------------------------------
// lif_ctrl
// Sequencer of the LIF neuron bank: clearing pass after reset, then one
// item at a time through decay, multiply, sum and write-back steps.
// ----------------------------------------------------------------------------
`include "lif_neuron_update_assert.svh"

module lif_ctrl #(
   parameter int NUM_NEURONS = 256,
   parameter int IDX_W       = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lif_pkg::lif_cmd_type cmd,
   output logic [IDX_W-1:0]    clear_addr
);
   import lif_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECAY,
      ST_MULT,
      ST_SUM,
      ST_WRITE
   } state_type;

   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_NEURONS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clear_addr_ff, clear_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             commit;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clear_addr_in = clear_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECAY;
            end
         end
         ST_DECAY: state_in = ST_MULT;
         ST_MULT:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_WRITE;
         ST_WRITE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // commands to the datapath
   assign cmd.load     = accept;
   assign cmd.commit   = commit;
   assign cmd.clear_en = (state_ff == ST_CLEAR);
   assign clear_addr   = clear_addr_ff;
   assign rsp_valid    = rsp_valid_ff;

   // checks
   `LIF_ASSERT(a_commit_presents, clock, reset, commit |=> rsp_valid_ff, "commit lost its result beat")
   `LIF_ASSERT(a_accept_starts, clock, reset, accept |=> (state_ff == ST_DECAY), "accepted item not started")
   `LIF_ASSERT(a_write_stall_holds, clock, reset, ((state_ff == ST_WRITE) && !commit) |=> (state_ff == ST_WRITE), "stalled item dropped")
   `LIF_ASSERT(a_clear_runs_full, clock, reset, ((state_ff == ST_CLEAR) && (clear_addr_ff != LAST_ADDR)) |=> (state_ff == ST_CLEAR), "clearing pass cut short")
   `LIF_ASSERT_ALWAYS(a_no_accept_in_clear, clock, (state_ff == ST_CLEAR) |-> !req_ready, "input taken during clearing pass")

endmodule

@@ hw/rtl/lif_dp.sv @@
// ----------------------------------------------------------------------------
// lif_dp
// Datapath of the LIF neuron bank: register file, per-neuron state memory,
// decay / multiply / sum / write-back stages and the result register.
// ----------------------------------------------------------------------------
module lif_dp #(
   parameter int NUM_NEURONS        = 256,
   parameter int IDX_W              = 8,
   parameter int EXC_DECAY_SHIFT    = 4,
   parameter int INH_DECAY_SHIFT    = 4,
   parameter int MEMBRANE_SHIFT     = 4,
   parameter int THRESH_DECAY_SHIFT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lif_pkg::lif_cmd_type            cmd,
   input  logic [IDX_W-1:0]                clear_addr,
   input  lif_pkg::req_payload_type        req_payload,
   input  logic                            csr_write_en,
   input  logic [lif_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lif_pkg::DATA_W-1:0]      csr_write_data,
   output lif_pkg::rsp_payload_type        rsp_payload
);
   import lif_pkg::*;

   localparam int IDX_EXT_W = 16;

   csr_type                  csr_ff;
   neuron_state_type         state_mem [NUM_NEURONS];
   neuron_state_type         rd_data_ff;
   neuron_state_type         wr_data;
   neuron_state_type         step_row;
   neuron_state_type         init_row;
   logic [IDX_W-1:0]         rd_addr, wr_addr, item_addr;
   logic [IDX_EXT_W-1:0]     req_idx_ext, item_idx_ext;
   logic                     wr_en;
   logic                     in_range;
   req_payload_type          item_ff;
   rsp_payload_type          rsp_ff;

   // decay step
   logic signed [DATA_W-1:0] ge_sum, gi_sum, gi_clamped, ceiling_s;
   logic signed [DATA_W-1:0] diff_exc, diff_inh, leak_diff, th_diff, th_step;
   logic [REF_COUNT_W-1:0]   count_inc;
   logic                     count_done;
   logic signed [DATA_W-1:0] ge_dec_ff, gi_dec_ff, leak_ff, th_dec_ff;
   logic signed [DIFF_W-1:0] d_exc_ff, d_inh_ff;
   logic [REF_COUNT_W-1:0]   ref_count_ff;
   logic                     ref_flag_ff;

   // multiply and sum steps
   logic signed [PROD_W-1:0] prod_exc, prod_inh;
   logic signed [DATA_W-1:0] drive_exc_ff, drive_inh_ff, sum_ff;

   // write-back step
   logic signed [DATA_W-1:0] v_step, v_pre, ge_pre, gi_pre;
   logic                     refractory;
   logic                     fire;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_REST_POTENTIAL:      csr_ff.rest_potential      <= $signed(csr_write_data);
            CSR_EXCITATORY_REVERSAL: csr_ff.excitatory_reversal <= $signed(csr_write_data);
            CSR_INHIBITORY_REVERSAL: csr_ff.inhibitory_reversal <= $signed(csr_write_data);
            CSR_INHIBITORY_CEILING:  csr_ff.inhibitory_ceiling  <= csr_write_data[INPUT_W-1:0];
            CSR_THRESHOLD_INCREMENT: csr_ff.threshold_increment <= csr_write_data[INPUT_W-1:0];
            CSR_THRESHOLD_START:     csr_ff.threshold_start     <= $signed(csr_write_data);
            CSR_REFRACTORY_LENGTH:   csr_ff.refractory_length   <= csr_write_data[REF_LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // addressing
   assign req_idx_ext  = IDX_EXT_W'(req_payload.neuron_index);
   assign item_idx_ext = IDX_EXT_W'(item_ff.neuron_index);
   assign rd_addr      = req_idx_ext[IDX_W-1:0];
   assign item_addr    = item_idx_ext[IDX_W-1:0];
   assign in_range     = (item_idx_ext < IDX_EXT_W'(NUM_NEURONS));

   // state memory: one row per neuron, registered read on accept
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      if (cmd.load) begin
         rd_data_ff <= state_mem[rd_addr];
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
   end

   // decay: conductances, reversal differences, threshold relax, refractory count
   always_comb begin
      ge_sum = rd_data_ff.g_exc
             + $signed({1'b0, item_ff.excitatory_input})
             - (rd_data_ff.g_exc >>> (1 + EXC_DECAY_SHIFT));
      gi_sum = rd_data_ff.g_inh
             + $signed({1'b0, item_ff.inhibitory_input})
             - (rd_data_ff.g_inh >>> (1 + INH_DECAY_SHIFT));
      ceiling_s  = $signed({1'b0, csr_ff.inhibitory_ceiling});
      gi_clamped = (gi_sum > ceiling_s) ? ceiling_s : gi_sum;
      diff_exc   = csr_ff.excitatory_reversal - rd_data_ff.membrane;
      diff_inh   = csr_ff.inhibitory_reversal - rd_data_ff.membrane;
      leak_diff  = csr_ff.rest_potential - rd_data_ff.membrane;
      th_diff    = csr_ff.rest_potential - rd_data_ff.threshold;
      th_step    = rd_data_ff.threshold + (th_diff >>> (1 + THRESH_DECAY_SHIFT));
      count_inc  = rd_data_ff.ref_count + 1'b1;
      count_done = (count_inc > REF_COUNT_W'({csr_ff.refractory_length, 1'b0}));
   end

   always_ff @(posedge clock) begin
      ge_dec_ff    <= ge_sum;
      gi_dec_ff    <= gi_clamped;
      d_exc_ff     <= $signed(diff_exc[DATA_W-1:DIFF_SHIFT]);
      d_inh_ff     <= $signed(diff_inh[DATA_W-1:DIFF_SHIFT]);
      leak_ff      <= leak_diff >>> 1;
      th_dec_ff    <= item_ff.resting_phase ? rd_data_ff.threshold : th_step;
      ref_count_ff <= count_done ? '0 : count_inc;
      ref_flag_ff  <= !count_done;
   end

   // multiply: conductance times scaled difference, product scaled down
   assign prod_exc = ge_dec_ff * d_exc_ff;
   assign prod_inh = gi_dec_ff * d_inh_ff;

   always_ff @(posedge clock) begin
      drive_exc_ff <= prod_exc[PRODUCT_SHIFT+DATA_W-1:PRODUCT_SHIFT];
      drive_inh_ff <= prod_inh[PRODUCT_SHIFT+DATA_W-1:PRODUCT_SHIFT];
   end

   // sum of leak and both drives
   always_ff @(posedge clock) begin
      sum_ff <= leak_ff + drive_exc_ff + drive_inh_ff;
   end

   // write-back: membrane update, fire check, new row
   always_comb begin
      refractory = rd_data_ff.ref_flag;
      v_step     = rd_data_ff.membrane + (sum_ff >>> MEMBRANE_SHIFT);
      v_pre      = refractory ? rd_data_ff.membrane : v_step;
      ge_pre     = refractory ? rd_data_ff.g_exc    : ge_dec_ff;
      gi_pre     = refractory ? rd_data_ff.g_inh    : gi_dec_ff;
      fire       = (v_pre > th_dec_ff);

      step_row.membrane        = fire ? csr_ff.rest_potential : v_pre;
      step_row.threshold       = fire ? (th_dec_ff + $signed({1'b0, csr_ff.threshold_increment}))
                                      : th_dec_ff;
      step_row.g_exc           = fire ? '0 : ge_pre;
      step_row.g_inh           = fire ? '0 : gi_pre;
      step_row.ref_count       = refractory ? ref_count_ff : rd_data_ff.ref_count;
      step_row.ref_flag        = fire || (refractory && ref_flag_ff);

      init_row                 = '0;
      init_row.membrane        = csr_ff.rest_potential;
      init_row.threshold       = csr_ff.threshold_start;
   end

   // memory write port: clearing pass or item write-back
   always_comb begin
      wr_en   = cmd.clear_en || (cmd.commit && in_range);
      wr_addr = cmd.clear_en ? clear_addr : item_addr;
      priority if (cmd.clear_en) begin
         wr_data = '0;
      end else if (item_ff.op == OP_INIT) begin
         wr_data = init_row;
      end else begin
         wr_data = step_row;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         priority if (!in_range) begin
            rsp_ff <= '0;
         end else if (item_ff.op == OP_INIT) begin
            rsp_ff.spike     <= 1'b0;
            rsp_ff.membrane  <= csr_ff.rest_potential;
            rsp_ff.threshold <= csr_ff.threshold_start;
         end else begin
            rsp_ff.spike     <= fire;
            rsp_ff.membrane  <= step_row.membrane;
            rsp_ff.threshold <= step_row.threshold;
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/lif_neuron_update.sv @@
// ----------------------------------------------------------------------------
// lif_neuron_update
// Bank of conductance-based leaky integrate-and-fire neurons with adaptive
// threshold and refractory period.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one item per beat: op (step or init), neuron_index and
//   the excitatory / inhibitory inputs. rsp_bus returns one beat per item:
//   spike flag, membrane and threshold after the update. csr_* writes the
//   seven configuration registers, one per cycle with csr_write_en high,
//   while no item is in flight.
//   The state memory is read once and written once per item, with decay,
//   multiply, sum and write-back steps between; the next item is taken
//   only after the write-back.
//   Reset: the configuration registers and rsp valid go to zero, then a
//   clearing pass writes a zero row to every neuron, with req ready held low.
//   Stall: the result register holds a beat until rsp ready; the next item
//   may be accepted and runs up to write-back, where it waits for the
//   result register to free up.
// ----------------------------------------------------------------------------
module lif_neuron_update #(
   parameter int NUM_NEURONS        = 256,
   parameter int EXC_DECAY_SHIFT    = 4,
   parameter int INH_DECAY_SHIFT    = 4,
   parameter int MEMBRANE_SHIFT     = 4,
   parameter int THRESH_DECAY_SHIFT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   lif_stream_if.sink                      req_bus,
   lif_stream_if.source                    rsp_bus,
   input  logic                            csr_write_en,
   input  logic [lif_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lif_pkg::DATA_W-1:0]      csr_write_data
);
   import lif_pkg::*;

   localparam int IDX_W = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;

   lif_cmd_type      cmd;
   logic [IDX_W-1:0] clear_addr;
   rsp_payload_type  rsp_payload;

   // sequencer
   lif_ctrl #(
      .NUM_NEURONS (NUM_NEURONS),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .cmd        (cmd),
      .clear_addr (clear_addr)
   );

   // state memory and arithmetic
   lif_dp #(
      .NUM_NEURONS        (NUM_NEURONS),
      .IDX_W              (IDX_W),
      .EXC_DECAY_SHIFT    (EXC_DECAY_SHIFT),
      .INH_DECAY_SHIFT    (INH_DECAY_SHIFT),
      .MEMBRANE_SHIFT     (MEMBRANE_SHIFT),
      .THRESH_DECAY_SHIFT (THRESH_DECAY_SHIFT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .clear_addr     (clear_addr),
      .req_payload    (req_bus.payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_payload    (rsp_payload)
   );

   assign rsp_bus.payload = rsp_payload;

endmodule

@@ bench/tb_lif_neuron_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lif_neuron_update
// Self-checking bench for the LIF neuron bank. A short table of directed
// beats (reset state, init, field extremes, a full spike and refractory
// cycle) is followed by random traffic under six register settings. Every
// result beat is compared field by field against a fixed table value or a
// cycle-free neuron model kept in this file. Request bursts, response stalls
// and one long response hold-off keep the pipeline busy and back-pressured.
// ----------------------------------------------------------------------------
module tb_lif_neuron_update;
   import lif_pkg::*;

   localparam int BANK_SIZE       = 256;
   localparam int EXC_SHIFT       = 4;
   localparam int INH_SHIFT       = 4;
   localparam int MEM_SHIFT       = 4;
   localparam int THR_SHIFT       = 8;
   localparam int PHASE_COUNT     = 6;
   localparam int ITEMS_PER_PHASE = 171;
   localparam int RSP_LONG_HOLD   = 100;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int TAIL_CYCLES     = 12;
   localparam int MAX_PRINTED     = 40;

   localparam logic [INPUT_W-1:0] INPUT_MAX = '1;
   localparam logic [DATA_W-1:0]  DATA_MAX  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0]  DATA_MIN  = 32'h8000_0000;

   // register setting used by the directed table
   localparam logic [DATA_W-1:0] D_REST  = -32'sd65536;
   localparam logic [DATA_W-1:0] D_EREV  = 32'sd0;
   localparam logic [DATA_W-1:0] D_IREV  = -32'sd90000;
   localparam logic [DATA_W-1:0] D_CEIL  = 32'd60000;
   localparam logic [DATA_W-1:0] D_INC   = 32'd4096;
   localparam logic [DATA_W-1:0] D_START = -32'sd50000;
   localparam logic [DATA_W-1:0] D_REFR  = 32'd2;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef struct {
      req_payload_type item;
      bit              fixed;
      rsp_payload_type value;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_write_data;

   lif_stream_if #(.payload_type(req_payload_type)) req_bus ();
   lif_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   lif_neuron_update #(
      .NUM_NEURONS        (BANK_SIZE),
      .EXC_DECAY_SHIFT    (EXC_SHIFT),
      .INH_DECAY_SHIFT    (INH_SHIFT),
      .MEMBRANE_SHIFT     (MEM_SHIFT),
      .THRESH_DECAY_SHIFT (THR_SHIFT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // model state: register copy and one row per neuron
   csr_type          model_csr;
   neuron_state_type bank_state [BANK_SIZE];

   rsp_payload_type  expected_q [$];
   stim_row_type     directed_rows [$];
   rsp_payload_type  got_beat;
   rsp_payload_type  want_beat;

   int beats_sent;
   int init_sent;
   int results_seen;
   int spikes_seen;
   int mismatch_count;
   int settings_used;
   int long_holds;
   int idle_cycles;
   bit rsp_hold_request;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ((g * ((rev - v) >>> 7)) >>> 10), cut to 32 bits
   function automatic logic signed [DATA_W-1:0] conductance_drive(
      input logic signed [DATA_W-1:0] g,
      input logic signed [DATA_W-1:0] rev,
      input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0]   gap;
      logic signed [2*DATA_W-1:0] prod;
      gap  = rev - v;
      gap  = gap >>> DIFF_SHIFT;
      prod = g * gap;
      prod = prod >>> PRODUCT_SHIFT;
      return prod[DATA_W-1:0];
   endfunction

   // one neuron update, applied to the model bank
   function automatic rsp_payload_type neuron_step(input req_payload_type item);
      neuron_state_type         row;
      rsp_payload_type          outcome;
      logic signed [DATA_W-1:0] v, th, ge, gi, cur, pull;
      logic [REF_COUNT_W-1:0]   count;
      outcome = '0;
      // an index past the bank leaves everything alone and returns zeros
      if (item.neuron_index >= BANK_SIZE) return outcome;
      row = bank_state[item.neuron_index];
      if (item.op == OP_INIT) begin
         row = '0;
         row.membrane  = model_csr.rest_potential;
         row.threshold = model_csr.threshold_start;
         bank_state[item.neuron_index] = row;
         outcome.membrane  = row.membrane;
         outcome.threshold = row.threshold;
         return outcome;
      end
      v  = row.membrane;
      th = row.threshold;
      ge = row.g_exc;
      gi = row.g_inh;
      if (!row.ref_flag) begin
         // decay plus input, clamp inhibition, integrate toward reversals
         ge = ge + $signed({1'b0, item.excitatory_input}) - (ge >>> (EXC_SHIFT + 1));
         gi = gi + $signed({1'b0, item.inhibitory_input}) - (gi >>> (INH_SHIFT + 1));
         if (gi > $signed({1'b0, model_csr.inhibitory_ceiling}))
            gi = $signed({1'b0, model_csr.inhibitory_ceiling});
         cur = conductance_drive(ge, model_csr.excitatory_reversal, v)
             + conductance_drive(gi, model_csr.inhibitory_reversal, v);
         pull = model_csr.rest_potential - v;
         pull = (pull >>> 1) + cur;
         v    = v + (pull >>> MEM_SHIFT);
      end else begin
         // refractory: count only, leave once past twice the length
         count = row.ref_count + 1'b1;
         if (count > {model_csr.refractory_length, 1'b0}) begin
            count        = '0;
            row.ref_flag = 1'b0;
         end
         row.ref_count = count;
      end
      if (!item.resting_phase) begin
         pull = model_csr.rest_potential - th;
         th   = th + (pull >>> (THR_SHIFT + 1));
      end
      if (v > th) begin
         th            = th + $signed({1'b0, model_csr.threshold_increment});
         ge            = '0;
         gi            = '0;
         v             = model_csr.rest_potential;
         outcome.spike = 1'b1;
         row.ref_flag  = 1'b1;
      end
      row.membrane  = v;
      row.threshold = th;
      row.g_exc     = ge;
      row.g_inh     = gi;
      bank_state[item.neuron_index] = row;
      outcome.membrane  = v;
      outcome.threshold = th;
      return outcome;
   endfunction

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("tb: %s mismatch on result %0d at %0t: got %h, expected %h",
                  field, results_seen, $time, got, want);
   endtask

   // one register write per cycle; the model copy keeps the implemented bits
   task automatic write_register(input csr_index_type idx, input logic [DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      case (idx)
         CSR_REST_POTENTIAL:      model_csr.rest_potential      = data;
         CSR_EXCITATORY_REVERSAL: model_csr.excitatory_reversal = data;
         CSR_INHIBITORY_REVERSAL: model_csr.inhibitory_reversal = data;
         CSR_INHIBITORY_CEILING:  model_csr.inhibitory_ceiling  = data[INPUT_W-1:0];
         CSR_THRESHOLD_INCREMENT: model_csr.threshold_increment = data[INPUT_W-1:0];
         CSR_THRESHOLD_START:     model_csr.threshold_start     = data;
         CSR_REFRACTORY_LENGTH:   model_csr.refractory_length   = data[REF_LENGTH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [DATA_W-1:0] rest, erev, irev, ceil, inc,
                                input logic [DATA_W-1:0] start, refr);
      write_register(CSR_REST_POTENTIAL, rest);
      write_register(CSR_EXCITATORY_REVERSAL, erev);
      write_register(CSR_INHIBITORY_REVERSAL, irev);
      write_register(CSR_INHIBITORY_CEILING, ceil);
      write_register(CSR_THRESHOLD_INCREMENT, inc);
      write_register(CSR_THRESHOLD_START, start);
      write_register(CSR_REFRACTORY_LENGTH, refr);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic add_row(input op_type op, input int idx,
                          input logic [INPUT_W-1:0] exc, inh, input bit resting,
                          input bit fixed, input logic [DATA_W-1:0] mem, th);
      stim_row_type row;
      row.item.op               = op;
      row.item.neuron_index     = INDEX_W'(idx);
      row.item.excitatory_input = exc;
      row.item.inhibitory_input = inh;
      row.item.resting_phase    = resting;
      row.fixed                 = fixed;
      row.value                 = '0;
      row.value.membrane        = mem;
      row.value.threshold       = th;
      directed_rows.push_back(row);
   endtask

   // present one beat (called at a falling edge), predict it once accepted
   task automatic offer(input req_payload_type item, input bit fixed,
                        input rsp_payload_type fixed_value);
      rsp_payload_type predicted;
      req_bus.payload <= item;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predicted = neuron_step(item);
      expected_q.push_back(fixed ? fixed_value : predicted);
      beats_sent++;
      if (item.op == OP_INIT) init_sent++;
      @(negedge clock);
   endtask

   // sender pause until every outstanding result is back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0);
   endtask

   task automatic run_random_phase(input int scale, input bit back_to_back);
      req_payload_type item;
      int              burst_left;
      int              gap;
      int              n;
      burst_left = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (back_to_back || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         // mostly steps on a small pool of neurons so spikes and refractory runs happen
         item.op           = ($urandom_range(0, 11) == 0) ? OP_INIT : OP_STEP;
         item.neuron_index = INDEX_W'(($urandom_range(0, 3) == 0)
                                      ? $urandom_range(0, BANK_SIZE - 1)
                                      : $urandom_range(0, 15));
         case ($urandom_range(0, 7))
            0: begin
               item.excitatory_input = INPUT_W'($urandom);
               item.inhibitory_input = INPUT_W'($urandom);
            end
            1: begin
               item.excitatory_input = $urandom_range(0, 1) ? INPUT_MAX : '0;
               item.inhibitory_input = $urandom_range(0, 1) ? INPUT_MAX : '0;
            end
            default: begin
               item.excitatory_input = INPUT_W'($urandom_range(0, scale));
               item.inhibitory_input = INPUT_W'($urandom_range(0, scale));
            end
         endcase
         item.resting_phase = ($urandom_range(0, 3) == 0);
         offer(item, 1'b0, '0);
      end
   endtask

   // response side: stall pattern in segments, plus one long hold on request
   initial begin : rsp_stall_pattern
      stall_mode_type stall_mode;
      int             segment_left;
      rsp_bus.ready = 1'b0;
      stall_mode    = STALL_NONE;
      segment_left  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (RSP_LONG_HOLD - 1) @(negedge clock);
            rsp_hold_request = 1'b0;
            long_holds++;
         end else begin
            if (segment_left == 0) begin
               segment_left = $urandom_range(16, 160);
               stall_mode   = stall_mode_type'($urandom_range(0, 3));
            end
            segment_left--;
            case (stall_mode)
               STALL_NONE:     rsp_bus.ready <= 1'b1;
               STALL_LIGHT:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_bus.ready <= ((segment_left % 5) >= 2);
               default:        rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset && ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_beat = rsp_bus.payload;
         results_seen++;
         if (got_beat.spike) spikes_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result beat", got_beat.membrane, '0);
         end else begin
            want_beat = expected_q.pop_front();
            if (got_beat.spike !== want_beat.spike)
               report_mismatch("spike", DATA_W'(got_beat.spike), DATA_W'(want_beat.spike));
            if (got_beat.membrane !== want_beat.membrane)
               report_mismatch("membrane", got_beat.membrane, want_beat.membrane);
            if (got_beat.threshold !== want_beat.threshold)
               report_mismatch("threshold", got_beat.threshold, want_beat.threshold);
         end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: no beat for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int scale;
      int k;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_write_data  = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      model_csr       = '0;
      foreach (bank_state[i]) bank_state[i] = '0;
      rsp_hold_request = 1'b0;
      beats_sent      = 0;
      init_sent       = 0;
      results_seen    = 0;
      spikes_seen     = 0;
      mismatch_count  = 0;
      settings_used   = 0;
      long_holds      = 0;
      idle_cycles     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; row 0 runs on reset registers, the rest on the D_ setting
      add_row(OP_STEP, 0, '0, '0, 1'b0, 1'b1, '0, '0);
      add_row(OP_INIT, 0, '0, '0, 1'b0, 1'b1, D_REST, D_START);
      add_row(OP_INIT, 1, INPUT_MAX, INPUT_MAX, 1'b1, 1'b1, D_REST, D_START);
      add_row(OP_INIT, 255, '0, '0, 1'b0, 1'b1, D_REST, D_START);
      add_row(OP_INIT, 2, '0, '0, 1'b0, 1'b1, D_REST, D_START);
      add_row(OP_STEP, 0, '0, '0, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 0, '0, '0, 1'b1, 1'b0, '0, '0);
      add_row(OP_STEP, 1, INPUT_MAX, '0, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 1, INPUT_MAX, INPUT_MAX, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 255, '0, INPUT_MAX, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 255, 31'd1, 31'd1, 1'b1, 1'b0, '0, '0);
      // neuron never initialized: runs from the cleared row
      add_row(OP_STEP, 3, 31'd5000, '0, 1'b0, 1'b0, '0, '0);
      // drive neuron 2 over threshold, then through its refractory period
      repeat (3) add_row(OP_STEP, 2, 31'd100000, '0, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 2, 31'd100000, '0, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 2, 31'd100000, '0, 1'b1, 1'b0, '0, '0);
      add_row(OP_STEP, 2, 31'd100000, '0, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 2, 31'd100000, '0, 1'b1, 1'b0, '0, '0);
      add_row(OP_STEP, 2, 31'd100000, '0, 1'b0, 1'b0, '0, '0);
      add_row(OP_STEP, 2, '0, 31'd100000, 1'b0, 1'b0, '0, '0);
      add_row(OP_INIT, 2, 31'd100000, '0, 1'b0, 1'b1, D_REST, D_START);
      add_row(OP_STEP, 254, INPUT_MAX, INPUT_MAX, 1'b1, 1'b0, '0, '0);
      add_row(OP_STEP, 0, INPUT_MAX, INPUT_MAX, 1'b0, 1'b0, '0, '0);
      for (k = 0; k < directed_rows.size(); k++) begin
         if (k == 1) begin
            wait_for_results();
            load_settings(D_REST, D_EREV, D_IREV, D_CEIL, D_INC, D_START, D_REFR);
         end
         offer(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].value);
      end
      wait_for_results();

      // random traffic, one register setting per phase
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               load_settings(D_REST, D_EREV, D_IREV, D_CEIL, D_INC, D_START, 32'd3);
               scale = 2000;
               // long response hold-off while requests keep coming
               rsp_hold_request = 1'b1;
            end
            1: begin
               load_settings(DATA_MAX, DATA_MAX, DATA_MAX, '1, '1, DATA_MAX, '1);
               scale = 200000;
            end
            2: begin
               load_settings(DATA_MIN, DATA_MIN, DATA_MIN, '0, '0, DATA_MIN, '0);
               scale = 200000;
            end
            3: begin
               load_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
               scale = 1 << 20;
            end
            4: begin
               load_settings('0, 1 << 20, -(1 << 20), $urandom_range(0, 100000),
                             $urandom_range(0, 20000), $urandom_range(0, 30000),
                             $urandom_range(0, 7));
               scale = 5000;
            end
            default: begin
               load_settings(-$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 18),
                             -$urandom_range(0, 1 << 21), $urandom_range(0, 1 << 16),
                             '0, -$urandom_range(0, 1 << 19), 32'd1);
               scale = 20000;
            end
         endcase
         run_random_phase(scale, phase == 0);
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d beats sent (%0d init) under %0d register settings, %0d long holds",
               beats_sent, init_sent, settings_used, long_holds);
      $display("tb: %0d results compared, %0d spikes, %0d mismatches",
               results_seen, spikes_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lif_pkg.sv
hw/rtl/lif_stream_if.sv
hw/rtl/lif_ctrl.sv
hw/rtl/lif_dp.sv
hw/rtl/lif_neuron_update.sv
bench/tb_lif_neuron_update.sv
